// ===== rtl/mbet_pkg.sv =====
// Package for the Mandelbrot escape-time pixel block: widths, reset values,
// register indexes, request and response types and the saturation helper.
// Depends on nothing; every module of the block imports it.
package mbet_pkg;

  // Fixed-point format of c and z.
  localparam int FRAC_BITS = 24;
  localparam int ZW        = FRAC_BITS + 17;    // signed width of c and z
  localparam int MAG_W     = ZW - 1;            // magnitude of a clamped value
  localparam int HALF_W    = MAG_W / 2;         // operand half fed to the multiplier
  localparam int MUL_W     = (HALF_W > 25) ? HALF_W : 25;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = 2 * MAG_W;         // full product of two magnitudes
  localparam int EW        = ZW + 2;            // room for rr - ii + cre
  localparam int SUM_W     = ZW + 1;            // re + im

  localparam logic [MAG_W-1:0] ZMAX = {MAG_W{1'b1}};

  // Field and register widths.
  localparam int IDX_W   = 10;
  localparam int CNT_W   = 10;
  localparam int GRAY_W  = 8;
  localparam int RS_W    = 28;
  localparam int STEP_W  = 25;
  localparam int LIM_W   = 7;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 28;
  localparam int NUM_W   = CNT_W + GRAY_W;      // count * 255

  localparam logic [GRAY_W-1:0] GRAY_MAX = {GRAY_W{1'b1}};

  // Register indexes.
  localparam logic [CFG_IW-1:0] CFG_REAL_START = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_IMAG_START = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_REAL_STEP  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_IMAG_STEP  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MAX_ITER   = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_ESC_LIMIT  = 3'd5;

  // Register reset values.
  localparam logic signed [RS_W-1:0] RST_START    = -28'sd33554432;
  localparam logic [STEP_W-1:0]      RST_STEP     = 25'd83886;
  localparam logic [CNT_W-1:0]       RST_MAX_ITER = 10'd100;
  localparam logic [LIM_W-1:0]       RST_ESC      = 7'd16;

  // Product groups and partial-product positions of one iteration.
  localparam logic [1:0] GRP_RR  = 2'd0;
  localparam logic [1:0] GRP_II  = 2'd1;
  localparam logic [1:0] GRP_RI  = 2'd2;
  localparam logic [1:0] PART_LL = 2'd0;
  localparam logic [1:0] PART_LH = 2'd1;
  localparam logic [1:0] PART_HL = 2'd2;
  localparam logic [1:0] PART_HH = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0] column_index;
    logic [IDX_W-1:0] row_index;
  } mbet_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  iteration_count;
    logic              escaped;
    logic [GRAY_W-1:0] gray_level;
  } mbet_rsp_t;

  // Tag that travels with a partial product through the multiplier register.
  typedef struct packed {
    logic       vld;
    logic [1:0] grp;
    logic [1:0] part;
  } mbet_tag_t;

  // Start request for the gray-level divider.
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] den;
  } mbet_div_req_t;

  // Clamp a wide signed value to the range +-ZMAX.
  function automatic logic signed [ZW-1:0] clampz(input logic signed [EW-1:0] v);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = $signed({{(EW-MAG_W){1'b0}}, ZMAX});
    lo = -hi;
    if (v > hi) begin
      clampz = hi[ZW-1:0];
    end else if (v < lo) begin
      clampz = lo[ZW-1:0];
    end else begin
      clampz = v[ZW-1:0];
    end
  endfunction

endpackage

// ===== rtl/mbet_mul.sv =====
// Shared unsigned multiplier with a registered product.
// Depends on mbet_pkg for the operand and product widths.
module mbet_mul (
  input  logic                       clk_i,
  input  logic [mbet_pkg::MUL_W-1:0]  a_i,
  input  logic [mbet_pkg::MUL_W-1:0]  b_i,
  output logic [mbet_pkg::PROD_W-1:0] p_o
);
  import mbet_pkg::*;

  logic [PROD_W-1:0] p_q;

  // One product per cycle, registered before use.
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/mbet_div.sv =====
// Restoring divider for the gray level, one quotient bit per cycle.
// Depends on mbet_pkg for widths and the start request type.
module mbet_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbet_pkg::mbet_div_req_t       req_i,
  output logic                          done_o,
  output logic [mbet_pkg::NUM_W-1:0]    quot_o
);
  import mbet_pkg::*;

  localparam int DC_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] den_q, den_d;
  logic [DC_W-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W:0]   shifted;
  logic [CNT_W:0]   diff;
  logic             fits;

  // Shift the next numerator bit into the remainder and try the subtraction.
  assign shifted = {rem_q, quo_q[NUM_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = (shifted >= {1'b0, den_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = DC_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - DC_W'(1);
      if (cnt_q == DC_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state is reset; the data registers are loaded on start.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time pixel: maps a pixel to c and iterates z = z*z + c.
// The divider is skipped when the count is zero or the limit is one; one
// request is worked at a time, so a new one is taken only once the sequencer
// is back in idle after the result is registered. Each iteration issues twelve
// 20x20 partial products through one multiplier. Reset (asynchronous, active
// low) restores the register defaults and idles.
module mandelbrot_escape_time_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mbet_pkg::mbet_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mbet_pkg::mbet_rsp_t           out_rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mbet_pkg::CFG_IW-1:0]   cfg_index_i,
  input  logic [mbet_pkg::CFG_DW-1:0]   cfg_data_i
);
  import mbet_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_TEST = 3'd4;
  localparam logic [2:0] S_GRAY = 3'd5;
  localparam logic [2:0] S_DIVW = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  localparam logic [3:0] ISSUE_N = 4'd12;   // partial products per iteration
  localparam logic [3:0] MAP_IM  = 4'd1;
  localparam logic [3:0] MAP_END = 4'd2;

  // Configuration registers.
  logic signed [RS_W-1:0] real_start_q;
  logic signed [RS_W-1:0] imag_start_q;
  logic [STEP_W-1:0]      real_step_q;
  logic [STEP_W-1:0]      imag_step_q;
  logic [CNT_W-1:0]       max_iter_q;
  logic [LIM_W-1:0]       esc_limit_q;

  // Sequencer and datapath registers.
  logic [2:0]             state_q, state_d;
  logic [3:0]             cnt_q, cnt_d;
  mbet_req_t              pix_q, pix_d;
  logic signed [ZW-1:0]   cre_q, cre_d, cim_q, cim_d;
  logic signed [ZW-1:0]   zre_q, zre_d, zim_q, zim_d;
  logic [MAG_W-1:0]       re_mag_q, re_mag_d, im_mag_q, im_mag_d;
  logic                   ri_neg_q, ri_neg_d;
  logic [MAG_W-1:0]       rr_q, rr_d, ii_q, ii_d, ri_q, ri_d;
  logic [ACC_W-1:0]       acc_q, acc_d;
  mbet_tag_t              tag_q, tag_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic                   esc_q, esc_d;
  logic [GRAY_W-1:0]      gray_q, gray_d;
  mbet_rsp_t              out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  // Shared multiplier and divider connections.
  logic [MUL_W-1:0]       mul_a, mul_b;
  logic [PROD_W-1:0]      mul_p;
  mbet_div_req_t          div_req;
  logic                   div_done;
  logic [NUM_W-1:0]       div_quot;

  mbet_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  mbet_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Operand selection: mapping products, then the halves of |re| and |im|.
  logic [1:0]        iss_grp, iss_part;
  logic [MAG_W-1:0]  src_a, src_b;
  logic [HALF_W-1:0] half_a, half_b;

  assign iss_grp  = cnt_q[3:2];
  assign iss_part = cnt_q[1:0];
  assign src_a    = (iss_grp == GRP_II) ? im_mag_q : re_mag_q;
  assign src_b    = (iss_grp == GRP_RR) ? re_mag_q : im_mag_q;
  assign half_a   = iss_part[1] ? src_a[MAG_W-1:HALF_W] : src_a[HALF_W-1:0];
  assign half_b   = iss_part[0] ? src_b[MAG_W-1:HALF_W] : src_b[HALF_W-1:0];

  always_comb begin
    if (state_q == S_MAP) begin
      if (cnt_q == '0) begin
        mul_a = MUL_W'(pix_q.row_index);
        mul_b = MUL_W'(real_step_q);
      end else begin
        mul_a = MUL_W'(pix_q.column_index);
        mul_b = MUL_W'(imag_step_q);
      end
    end else begin
      mul_a = MUL_W'(half_a);
      mul_b = MUL_W'(half_b);
    end
  end

  // Partial-product accumulation; the last part of a product saturates it.
  logic [ACC_W-1:0] pp_ext, pp_shift, acc_base, acc_sum;
  logic [MAG_W-1:0] prod_sat;

  assign pp_ext = ACC_W'(mul_p[2*HALF_W-1:0]);

  always_comb begin
    case (tag_q.part)
      PART_LL: pp_shift = pp_ext;
      PART_HH: pp_shift = pp_ext << (2 * HALF_W);
      default: pp_shift = pp_ext << HALF_W;
    endcase
  end

  assign acc_base = (tag_q.part == PART_LL) ? '0 : acc_q;
  assign acc_sum  = acc_base + pp_shift;
  assign prod_sat = (|acc_sum[ACC_W-1:FRAC_BITS+MAG_W]) ? ZMAX
                                                        : acc_sum[FRAC_BITS +: MAG_W];

  // Mapping sums; the coordinate range keeps them well inside +-ZMAX.
  logic signed [ZW-1:0] map_p, rs_x, is_x;

  assign map_p = $signed(ZW'(mul_p[IDX_W+STEP_W-1:0]));
  assign rs_x  = $signed({{(ZW-RS_W){real_start_q[RS_W-1]}}, real_start_q});
  assign is_x  = $signed({{(ZW-RS_W){imag_start_q[RS_W-1]}}, imag_start_q});

  // New z from the saturated products.
  logic signed [EW-1:0] rr_x, ii_x, ri2_x, cre_x, cim_x, nre_w, nim_w;

  assign rr_x  = $signed({{(EW-MAG_W){1'b0}}, rr_q});
  assign ii_x  = $signed({{(EW-MAG_W){1'b0}}, ii_q});
  assign ri2_x = $signed({{(EW-MAG_W-1){1'b0}}, ri_q, 1'b0});
  assign cre_x = $signed({{(EW-ZW){cre_q[ZW-1]}}, cre_q});
  assign cim_x = $signed({{(EW-ZW){cim_q[ZW-1]}}, cim_q});
  assign nre_w = rr_x - ii_x + cre_x;
  assign nim_w = ri_neg_q ? (cim_x - ri2_x) : (cim_x + ri2_x);

  // Band test on re + im and magnitudes for the next iteration.
  logic signed [SUM_W-1:0] sum_w, band_w, nband_w;
  logic signed [ZW-1:0]    zre_ngt, zim_ngt;
  logic                    leave;
  logic [CNT_W-1:0]        n_inc;

  assign sum_w   = $signed({zre_q[ZW-1], zre_q}) + $signed({zim_q[ZW-1], zim_q});
  assign band_w  = $signed({{(SUM_W-LIM_W-FRAC_BITS){1'b0}}, esc_limit_q,
                            {FRAC_BITS{1'b0}}});
  assign nband_w = -band_w;
  assign leave   = (sum_w > band_w) || (sum_w < nband_w);
  assign zre_ngt = -zre_q;
  assign zim_ngt = -zim_q;
  assign n_inc   = n_q + CNT_W'(1);

  // Divider request: floor(count * 255 / (limit - 1)).
  assign div_req.start = (state_q == S_GRAY) && (n_q != '0) && (max_iter_q != CNT_W'(1));
  assign div_req.num   = {n_q, {GRAY_W{1'b0}}} - NUM_W'(n_q);
  assign div_req.den   = max_iter_q - CNT_W'(1);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pix_d       = pix_q;
    cre_d       = cre_q;
    cim_d       = cim_q;
    zre_d       = zre_q;
    zim_d       = zim_q;
    re_mag_d    = re_mag_q;
    im_mag_d    = im_mag_q;
    ri_neg_d    = ri_neg_q;
    rr_d        = rr_q;
    ii_d        = ii_q;
    ri_d        = ri_q;
    acc_d       = acc_q;
    n_d         = n_q;
    esc_d       = esc_q;
    gray_d      = gray_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    tag_d.vld   = (state_q == S_ITER) && (cnt_q < ISSUE_N);
    tag_d.grp   = iss_grp;
    tag_d.part  = iss_part;

    // Fold the product that left the multiplier this cycle.
    if (tag_q.vld) begin
      acc_d = acc_sum;
      if (tag_q.part == PART_HH) begin
        case (tag_q.grp)
          GRP_RR:  rr_d = prod_sat;
          GRP_II:  ii_d = prod_sat;
          default: ri_d = prod_sat;
        endcase
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pix_d   = in_req_i;
          cnt_d   = '0;
          state_d = S_MAP;
        end
      end
      S_MAP: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == MAP_IM) begin
          cre_d = rs_x + map_p;
        end
        if (cnt_q == MAP_END) begin
          cim_d    = is_x + map_p;
          zre_d    = '0;
          zim_d    = '0;
          re_mag_d = '0;
          im_mag_d = '0;
          ri_neg_d = 1'b0;
          n_d      = '0;
          esc_d    = 1'b0;
          cnt_d    = '0;
          state_d  = (max_iter_q == '0) ? S_GRAY : S_ITER;
        end
      end
      S_ITER: begin
        if (cnt_q == ISSUE_N) begin
          cnt_d   = '0;
          state_d = S_UPD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      S_UPD: begin
        zre_d   = clampz(nre_w);
        zim_d   = clampz(nim_w);
        state_d = S_TEST;
      end
      S_TEST: begin
        re_mag_d = zre_q[ZW-1] ? zre_ngt[MAG_W-1:0] : zre_q[MAG_W-1:0];
        im_mag_d = zim_q[ZW-1] ? zim_ngt[MAG_W-1:0] : zim_q[MAG_W-1:0];
        ri_neg_d = zre_q[ZW-1] ^ zim_q[ZW-1];
        if (leave) begin
          esc_d   = 1'b1;
          state_d = S_GRAY;
        end else begin
          n_d     = n_inc;
          state_d = (n_inc == max_iter_q) ? S_GRAY : S_ITER;
        end
      end
      S_GRAY: begin
        if (n_q == '0) begin
          gray_d  = '0;
          state_d = S_FIN;
        end else if (max_iter_q == CNT_W'(1)) begin
          gray_d  = GRAY_MAX;
          state_d = S_FIN;
        end else begin
          state_d = S_DIVW;
        end
      end
      S_DIVW: begin
        if (div_done) begin
          gray_d  = (|div_quot[NUM_W-1:GRAY_W]) ? GRAY_MAX : div_quot[GRAY_W-1:0];
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.iteration_count = n_q;
          out_d.escaped         = esc_q;
          out_d.gray_level      = gray_q;
          out_valid_d           = 1'b1;
          state_d               = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      tag_q        <= '0;
      out_valid_q  <= 1'b0;
      real_start_q <= RST_START;
      imag_start_q <= RST_START;
      real_step_q  <= RST_STEP;
      imag_step_q  <= RST_STEP;
      max_iter_q   <= RST_MAX_ITER;
      esc_limit_q  <= RST_ESC;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      tag_q       <= tag_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_REAL_START: real_start_q <= $signed(cfg_data_i[RS_W-1:0]);
          CFG_IMAG_START: imag_start_q <= $signed(cfg_data_i[RS_W-1:0]);
          CFG_REAL_STEP:  real_step_q  <= cfg_data_i[STEP_W-1:0];
          CFG_IMAG_STEP:  imag_step_q  <= cfg_data_i[STEP_W-1:0];
          CFG_MAX_ITER:   max_iter_q   <= cfg_data_i[CNT_W-1:0];
          CFG_ESC_LIMIT:  esc_limit_q  <= cfg_data_i[LIM_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    pix_q    <= pix_d;
    cre_q    <= cre_d;
    cim_q    <= cim_d;
    zre_q    <= zre_d;
    zim_q    <= zim_d;
    re_mag_q <= re_mag_d;
    im_mag_q <= im_mag_d;
    ri_neg_q <= ri_neg_d;
    rr_q     <= rr_d;
    ii_q     <= ii_d;
    ri_q     <= ri_d;
    acc_q    <= acc_d;
    n_q      <= n_d;
    esc_q    <= esc_d;
    gray_q   <= gray_d;
    out_q    <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A partial product only comes back while the iteration sequence runs.
  a_tag_in_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_q.vld |-> (state_q == S_ITER))
    else $error("partial product returned outside the iteration phase");

  // The divider only finishes while the sequencer waits for it.
  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVW))
    else $error("divider finished while not awaited");

  // An accepted request always starts the mapping step.
  a_accept_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_MAP))
    else $error("accepted request did not start mapping");

  // A new result appears only from the final state.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result raised outside the final state");

  // The issue counter never runs past the last partial product.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ITER) |-> (cnt_q <= ISSUE_N))
    else $error("issue counter out of range");

endmodule
